// ===== sv/desf_pkg.sv =====
// ============================================================================
// desf_pkg
// Shared types, constants and the FNV-1a fold for the entity state filter.
// ============================================================================
package desf_pkg;

   localparam int STALE_ENTRIES_DEF = 64;
   localparam int FOLD_ENTRIES_DEF  = 256;
   localparam int MAX_TRACKED_DEF   = 256;

   localparam logic [15:0] HDR_BYTES   = 16'd12;
   localparam logic [7:0]  ES_KIND     = 8'd1;
   localparam logic [7:0]  VER_MIN     = 8'd5;
   localparam logic [7:0]  VER_MAX     = 8'd7;
   localparam logic [31:0] FNV_BASIS   = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME   = 32'd16777619;
   localparam logic [30:0] WRAP_GAP    = 31'h4000_0000;

   // register indexes
   localparam logic [2:0] CSR_FILT_ON   = 3'd0;
   localparam logic [2:0] CSR_EX_MATCH  = 3'd1;
   localparam logic [2:0] CSR_SAT_SITE  = 3'd2;
   localparam logic [2:0] CSR_SAT_APP   = 3'd3;
   localparam logic [2:0] CSR_SAT_ENT   = 3'd4;

   // verdict codes
   localparam logic [2:0] VD_ACCEPT   = 3'd0;
   localparam logic [2:0] VD_MALFORM  = 3'd1;
   localparam logic [2:0] VD_EXERCISE = 3'd2;
   localparam logic [2:0] VD_OTHER    = 3'd3;
   localparam logic [2:0] VD_STALE    = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_SSCAN, ST_SDONE, ST_HASH, ST_FSCAN, ST_FDONE, ST_OUT
   } desf_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request
      logic chk;        // evaluate header checks
      logic sclr;       // clear stale scan index
      logic sstep;      // examine one stale entry
      logic sfin;       // resolve stale scan
      logic hstep;      // one FNV round
      logic fclr;       // clear fold scan index
      logic fstep;      // examine one fold entry
      logic ffin;       // resolve fold scan
      logic post;       // load output register
   } desf_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pass;       // header checks passed
      logic sdone;      // stale scan finished
      logic hdone;      // hash rounds finished
      logic need_fold;  // accepted non-satellite
      logic fdone;      // fold scan finished
      logic out_busy;   // output register holds an untaken response
   } desf_sts_type;

   // one FNV-1a round
   function automatic logic [31:0] fnv_round(input logic [31:0] h, input logic [7:0] b);
      logic [31:0] x;
      x = h ^ {24'd0, b};
      return x * FNV_PRIME;
   endfunction

   function automatic logic [1:0] classify(input logic [7:0] k, input logic [7:0] d);
      if (k == 8'd1 && d == 8'd5) return 2'd0;
      if (k == 8'd1 && d == 8'd1) return 2'd1;
      if (k == 8'd3 && d == 8'd1) return 2'd1;
      if (k == 8'd2) return 2'd2;
      return 2'd3;
   endfunction

endpackage

// ===== sv/desf_ram.sv =====
// ============================================================================
// desf_ram
// Generic single-port RAM with registered read.
// ============================================================================
module desf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write, and registered read of the addressed word
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end
endmodule

// ===== sv/desf_ctrl.sv =====
// ============================================================================
// desf_ctrl
// Sequencer: header check, stale scan, hash rounds, fold scan, response.
// ============================================================================
module desf_ctrl
   import desf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  desf_sts_type sts,
   output desf_cmd_type cmd
);
   desf_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_CHECK;
         ST_CHECK: state_in = sts.pass ? ST_SSCAN : ST_OUT;
         ST_SSCAN: if (sts.sdone) state_in = ST_SDONE;
         ST_SDONE: state_in = ST_HASH;
         ST_HASH:  if (sts.hdone) state_in = sts.need_fold ? ST_FSCAN : ST_OUT;
         ST_FSCAN: if (sts.fdone) state_in = ST_FDONE;
         ST_FDONE: state_in = ST_OUT;
         ST_OUT:   if (!sts.out_busy) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_CHECK: begin
            cmd.chk  = 1'b1;
            cmd.sclr = 1'b1;
         end
         ST_SSCAN: cmd.sstep = 1'b1;
         ST_SDONE: cmd.sfin  = 1'b1;
         ST_HASH: begin
            cmd.hstep = 1'b1;
            cmd.fclr  = 1'b1;
         end
         ST_FSCAN: cmd.fstep = 1'b1;
         ST_FDONE: cmd.ffin  = 1'b1;
         ST_OUT:   cmd.post  = !sts.out_busy;
         default: ;
      endcase
   end
endmodule

// ===== sv/desf_dp.sv =====
// ============================================================================
// desf_dp
// Datapath: request capture, stale and fold tables, FNV unit, result register.
// ============================================================================
module desf_dp
   import desf_pkg::*;
#(
   parameter int STALE_ENTRIES = STALE_ENTRIES_DEF,
   parameter int FOLD_ENTRIES  = FOLD_ENTRIES_DEF,
   parameter int MAX_TRACKED   = MAX_TRACKED_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  desf_cmd_type cmd,
   output desf_sts_type sts,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_wdata,
   input  logic [15:0]  req_packet_length,
   input  logic [7:0]   req_version,
   input  logic [7:0]   req_exercise,
   input  logic [7:0]   req_pdu_kind,
   input  logic [31:0]  req_raw_timestamp,
   input  logic         req_body_complete,
   input  logic [15:0]  req_entity_site,
   input  logic [15:0]  req_entity_app,
   input  logic [15:0]  req_entity_number,
   input  logic [7:0]   req_entity_kind,
   input  logic [7:0]   req_entity_domain,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [2:0]   rsp_verdict,
   output logic [31:0]  rsp_sequence_res,
   output logic [31:0]  rsp_folded_id,
   output logic [1:0]   rsp_object_class,
   output logic         rsp_sat_match,
   output logic         rsp_fold_collision,
   output logic [8:0]   rsp_tracked_count,
   output logic [31:0]  rsp_satellite_id
);
   localparam int SW = $clog2(STALE_ENTRIES > 1 ? STALE_ENTRIES : 2);
   localparam int FW = $clog2(FOLD_ENTRIES > 1 ? FOLD_ENTRIES : 2);
   localparam int SC = $clog2(STALE_ENTRIES + 1);
   localparam int FC = $clog2(FOLD_ENTRIES + 1);
   localparam int TW = $clog2(MAX_TRACKED + 1);
   localparam int CW = (FC > TW) ? FC : TW;

   // configuration
   logic        filt_on_ff;
   logic [7:0]  ex_match_ff;
   logic [15:0] sat_site_ff, sat_app_ff, sat_ent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         filt_on_ff  <= 1'b0;
         ex_match_ff <= '0;
         sat_site_ff <= '0;
         sat_app_ff  <= '0;
         sat_ent_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FILT_ON:  filt_on_ff  <= csr_wdata[0];
            CSR_EX_MATCH: ex_match_ff <= csr_wdata[7:0];
            CSR_SAT_SITE: sat_site_ff <= csr_wdata;
            CSR_SAT_APP:  sat_app_ff  <= csr_wdata;
            CSR_SAT_ENT:  sat_ent_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // captured request
   logic [15:0] len_ff;
   logic [7:0]  ver_ff, exer_ff, pk_ff, ek_ff, ed_ff;
   logic [30:0] ts_ff;
   logic        body_ff;
   logic [47:0] key_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         len_ff  <= req_packet_length;
         ver_ff  <= req_version;
         exer_ff <= req_exercise;
         pk_ff   <= req_pdu_kind;
         ts_ff   <= req_raw_timestamp[31:1];
         body_ff <= req_body_complete;
         key_ff  <= {req_entity_site, req_entity_app, req_entity_number};
         ek_ff   <= req_entity_kind;
         ed_ff   <= req_entity_domain;
      end
   end

   // header checks
   logic [2:0] pre_vd;
   always_comb begin
      if (len_ff < HDR_BYTES || ver_ff < VER_MIN || ver_ff > VER_MAX) begin
         pre_vd = VD_MALFORM;
      end else if (filt_on_ff && exer_ff != ex_match_ff) begin
         pre_vd = VD_EXERCISE;
      end else if (pk_ff != ES_KIND) begin
         pre_vd = VD_OTHER;
      end else if (!body_ff) begin
         pre_vd = VD_MALFORM;
      end else begin
         pre_vd = VD_ACCEPT;
      end
   end

   logic [2:0] vd_ff;
   // stale table: index ff walks; RAM read data arrives the cycle after its address
   logic [SC-1:0]          sidx_ff;
   logic                   srd_ff;      // read data in flight is valid
   logic [SW-1:0]          sraddr_ff;
   logic [STALE_ENTRIES-1:0] svalid_ff;
   logic                   shit_ff, sfree_ok_ff, sstale_ff;
   logic [SW-1:0]          shit_ix_ff, sfree_ix_ff;
   logic                   sdone_ff;
   logic [47:0]            skey_rd;
   logic [30:0]            stime_rd;
   logic                   s_we;
   logic [SW-1:0]          s_addr;

   // write phase on sfin for a fresh hit or a free slot, otherwise scan address
   always_comb begin
      s_we   = 1'b0;
      s_addr = sidx_ff[SW-1:0];
      if (cmd.sfin && vd_ff == VD_ACCEPT) begin
         if (shit_ff) begin
            s_we   = !sstale_ff;
            s_addr = shit_ix_ff;
         end else if (sfree_ok_ff) begin
            s_we   = 1'b1;
            s_addr = sfree_ix_ff;
         end
      end
   end

   desf_ram #(.WIDTH(48), .DEPTH(STALE_ENTRIES)) u_skeys (
      .clock(clock), .we(s_we), .addr(s_addr), .wdata(key_ff), .rdata(skey_rd));
   desf_ram #(.WIDTH(31), .DEPTH(STALE_ENTRIES)) u_stimes (
      .clock(clock), .we(s_we), .addr(s_addr), .wdata(ts_ff), .rdata(stime_rd));

   logic [30:0] sdiff;
   assign sdiff = stime_rd - ts_ff;

   // walk stale entries, compare the one read last cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         svalid_ff <= '0;
      end else if (s_we) begin
         svalid_ff[s_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sclr) begin
         sidx_ff     <= '0;
         srd_ff      <= 1'b0;
         shit_ff     <= 1'b0;
         sfree_ok_ff <= 1'b0;
         sstale_ff   <= 1'b0;
         sdone_ff    <= 1'b0;
      end else if (cmd.sstep) begin
         if (srd_ff && !shit_ff) begin
            if (svalid_ff[sraddr_ff]) begin
               if (skey_rd == key_ff) begin
                  shit_ff    <= 1'b1;
                  shit_ix_ff <= sraddr_ff;
                  sstale_ff  <= !(ts_ff == '0 || ts_ff >= stime_rd || sdiff >= WRAP_GAP);
               end
            end else if (!sfree_ok_ff) begin
               sfree_ok_ff <= 1'b1;
               sfree_ix_ff <= sraddr_ff;
            end
         end
         if (sidx_ff == SC'(STALE_ENTRIES)) begin
            sdone_ff <= 1'b1;
            srd_ff   <= 1'b0;
         end else begin
            sraddr_ff <= sidx_ff[SW-1:0];
            srd_ff    <= 1'b1;
            sidx_ff   <= sidx_ff + 1'b1;
         end
      end
   end

   // hash: six rounds, one multiply each
   logic [31:0] hash_ff;
   logic [2:0]  hcnt_ff;
   logic [7:0]  hbyte;
   always_comb begin
      case (hcnt_ff)
         3'd0:    hbyte = key_ff[47:40];
         3'd1:    hbyte = key_ff[39:32];
         3'd2:    hbyte = key_ff[31:24];
         3'd3:    hbyte = key_ff[23:16];
         3'd4:    hbyte = key_ff[15:8];
         default: hbyte = key_ff[7:0];
      endcase
   end

   logic is_sat;
   assign is_sat = key_ff == {sat_site_ff, sat_app_ff, sat_ent_ff};

   // fold table
   logic [FC-1:0]           fidx_ff;
   logic                    frd_ff;
   logic [FW-1:0]           fraddr_ff;
   logic [FOLD_ENTRIES-1:0] fvalid_ff;
   logic                    fhit_ff, ffree_ok_ff, fcoll_ff, fdone_ff;
   logic [FW-1:0]           fhit_ix_ff, ffree_ix_ff;
   logic [31:0]             fid_rd;
   logic [47:0]             fown_rd;
   logic                    fid_we, fown_we;
   logic [FW-1:0]           f_addr;
   logic [CW-1:0]           fcount_ff;

   always_comb begin
      fid_we  = 1'b0;
      fown_we = 1'b0;
      f_addr  = fidx_ff[FW-1:0];
      if (cmd.ffin) begin
         if (fhit_ff) begin
            fown_we = fcoll_ff;
            f_addr  = fhit_ix_ff;
         end else if (ffree_ok_ff) begin
            fid_we  = 1'b1;
            fown_we = 1'b1;
            f_addr  = ffree_ix_ff;
         end
      end
   end

   desf_ram #(.WIDTH(32), .DEPTH(FOLD_ENTRIES)) u_fids (
      .clock(clock), .we(fid_we), .addr(f_addr), .wdata(hash_ff), .rdata(fid_rd));
   desf_ram #(.WIDTH(48), .DEPTH(FOLD_ENTRIES)) u_fowners (
      .clock(clock), .we(fown_we), .addr(f_addr), .wdata(key_ff), .rdata(fown_rd));

   // track fold valid bits and count
   always_ff @(posedge clock) begin
      if (reset) begin
         fvalid_ff <= '0;
         fcount_ff <= '0;
      end else if (fid_we) begin
         fvalid_ff[f_addr] <= 1'b1;
         fcount_ff         <= fcount_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fclr) begin
         fidx_ff     <= '0;
         frd_ff      <= 1'b0;
         fhit_ff     <= 1'b0;
         ffree_ok_ff <= 1'b0;
         fcoll_ff    <= 1'b0;
         fdone_ff    <= 1'b0;
      end else if (cmd.fstep) begin
         if (frd_ff && !fhit_ff) begin
            if (fvalid_ff[fraddr_ff]) begin
               if (fid_rd == hash_ff) begin
                  fhit_ff    <= 1'b1;
                  fhit_ix_ff <= fraddr_ff;
                  fcoll_ff   <= fown_rd != key_ff;
               end
            end else if (!ffree_ok_ff) begin
               ffree_ok_ff <= 1'b1;
               ffree_ix_ff <= fraddr_ff;
            end
         end
         if (fidx_ff == FC'(FOLD_ENTRIES)) begin
            fdone_ff <= 1'b1;
            frd_ff   <= 1'b0;
         end else begin
            fraddr_ff <= fidx_ff[FW-1:0];
            frd_ff    <= 1'b1;
            fidx_ff   <= fidx_ff + 1'b1;
         end
      end
   end

   // verdict, hash, sequence and satellite
   logic [31:0] acc_ff, sat_id_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         sat_id_ff <= '0;
      end else begin
         if (cmd.sfin && vd_ff == VD_ACCEPT && !(shit_ff && sstale_ff)) begin
            acc_ff <= acc_ff + 1'b1;
         end
         if (cmd.hstep && hcnt_ff == 3'd6 && is_sat && vd_ff == VD_ACCEPT) begin
            sat_id_ff <= hash_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.chk) begin
         vd_ff   <= pre_vd;
         hash_ff <= FNV_BASIS;
         hcnt_ff <= '0;
      end else if (cmd.sfin && vd_ff == VD_ACCEPT && shit_ff && sstale_ff) begin
         vd_ff <= VD_STALE;
      end else if (cmd.hstep && hcnt_ff != 3'd6) begin
         hash_ff <= fnv_round(hash_ff, hbyte);
         hcnt_ff <= hcnt_ff + 1'b1;
      end
   end

   logic [8:0] total;
   always_comb begin
      if (fcount_ff >= CW'(MAX_TRACKED)) total = 9'(MAX_TRACKED > 511 ? 511 : MAX_TRACKED);
      else if (fcount_ff >= CW'(511) && CW > 9) total = 9'd511;
      else total = 9'(fcount_ff);
   end

   // output register
   logic ok;
   assign ok = vd_ff == VD_ACCEPT;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.post) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.post) begin
         rsp_verdict        <= vd_ff;
         rsp_sequence_res   <= ok ? acc_ff : '0;
         rsp_folded_id      <= ok ? hash_ff : '0;
         rsp_sat_match      <= ok && is_sat;
         rsp_object_class   <= (ok && !is_sat) ? classify(ek_ff, ed_ff) : 2'd0;
         rsp_fold_collision <= ok && !is_sat && fhit_ff && fcoll_ff;
         rsp_tracked_count  <= total;
         rsp_satellite_id   <= sat_id_ff;
      end
   end

   assign sts.pass      = pre_vd == VD_ACCEPT;
   assign sts.sdone     = sdone_ff;
   assign sts.hdone     = hcnt_ff == 3'd6;
   assign sts.need_fold = ok && !is_sat;
   assign sts.fdone     = fdone_ff;
   assign sts.out_busy  = rsp_valid && !rsp_ready;
endmodule

// ===== sv/dis_entity_state_filter.sv =====
// ============================================================================
// dis_entity_state_filter
// Entity-state PDU acceptance filter with stale and fold tables.
// ============================================================================
// Usage: one header-parsed PDU arrives per request on req_* (valid/ready);
// exactly one response leaves on rsp_* (valid/ready) per request.
// Registers are written on csr_* with csr_we; write only while idle.
// Flow: a request rejected by the header checks goes from the check state
// straight to its response. Any other request walks the stale table
// (one RAM read per cycle), runs six FNV rounds (one multiply per cycle)
// and, for accepted non-satellite entities, walks the fold table. One
// request is in work at a time.
// The response sits in an output register; the next request is taken as
// soon as the response is loaded, even while the receiver stalls, and a
// further response waits until the register frees.
// Reset clears valid bits, counters, the satellite id and the registers
// at once; no clearing pass is needed.
// ============================================================================
module dis_entity_state_filter
   import desf_pkg::*;
#(
   parameter int STALE_ENTRIES = STALE_ENTRIES_DEF,
   parameter int FOLD_ENTRIES  = FOLD_ENTRIES_DEF,
   parameter int MAX_TRACKED   = MAX_TRACKED_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_packet_length,
   input  logic [7:0]  req_version,
   input  logic [7:0]  req_exercise,
   input  logic [7:0]  req_pdu_kind,
   input  logic [31:0] req_raw_timestamp,
   input  logic        req_body_complete,
   input  logic [15:0] req_entity_site,
   input  logic [15:0] req_entity_app,
   input  logic [15:0] req_entity_number,
   input  logic [7:0]  req_entity_kind,
   input  logic [7:0]  req_entity_domain,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_verdict,
   output logic [31:0] rsp_sequence_res,
   output logic [31:0] rsp_folded_id,
   output logic [1:0]  rsp_object_class,
   output logic        rsp_sat_match,
   output logic        rsp_fold_collision,
   output logic [8:0]  rsp_tracked_count,
   output logic [31:0] rsp_satellite_id
);
   desf_cmd_type cmd;
   desf_sts_type sts;

   desf_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .sts(sts), .cmd(cmd));

   desf_dp #(
      .STALE_ENTRIES(STALE_ENTRIES), .FOLD_ENTRIES(FOLD_ENTRIES),
      .MAX_TRACKED(MAX_TRACKED)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_packet_length(req_packet_length), .req_version(req_version),
      .req_exercise(req_exercise), .req_pdu_kind(req_pdu_kind),
      .req_raw_timestamp(req_raw_timestamp), .req_body_complete(req_body_complete),
      .req_entity_site(req_entity_site), .req_entity_app(req_entity_app),
      .req_entity_number(req_entity_number), .req_entity_kind(req_entity_kind),
      .req_entity_domain(req_entity_domain),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_verdict(rsp_verdict),
      .rsp_sequence_res(rsp_sequence_res), .rsp_folded_id(rsp_folded_id),
      .rsp_object_class(rsp_object_class), .rsp_sat_match(rsp_sat_match),
      .rsp_fold_collision(rsp_fold_collision), .rsp_tracked_count(rsp_tracked_count),
      .rsp_satellite_id(rsp_satellite_id));
endmodule

// ===== sv/desf_checker.sv =====
// ============================================================================
// desf_checker
// Port-level checks of the filter's response behavior.
// ============================================================================
module desf_checker
   import desf_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_verdict,
   input logic [31:0] rsp_sequence_res,
   input logic [31:0] rsp_folded_id,
   input logic        rsp_sat_match,
   input logic        rsp_fold_collision
);
   // a stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_verdict))
      else $error("response dropped while stalled");

   // rejections carry no sequence or fold
   a_rej: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict != VD_ACCEPT |-> rsp_sequence_res == '0 &&
      rsp_folded_id == '0 && !rsp_fold_collision)
      else $error("rejected response carries data");

   // satellites never collide
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sat_match |-> !rsp_fold_collision)
      else $error("satellite reported a collision");

   // verdict codes stay in range
   a_vd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_verdict <= VD_STALE)
      else $error("bad verdict");
endmodule

bind dis_entity_state_filter desf_checker u_desf_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_verdict(rsp_verdict),
   .rsp_sequence_res(rsp_sequence_res), .rsp_folded_id(rsp_folded_id),
   .rsp_sat_match(rsp_sat_match), .rsp_fold_collision(rsp_fold_collision));

// ===== test/desf_checker.sv =====
// ----------------------------------------------------------------------------
// desf_monitor
// Watches the request, response and register ports of the entity state
// filter, predicts each response from its own copy of the tables and compares.
// ----------------------------------------------------------------------------
module desf_monitor
   import desf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [15:0] req_packet_length,
   input  logic [7:0]  req_version,
   input  logic [7:0]  req_exercise,
   input  logic [7:0]  req_pdu_kind,
   input  logic [31:0] req_raw_timestamp,
   input  logic        req_body_complete,
   input  logic [15:0] req_entity_site,
   input  logic [15:0] req_entity_app,
   input  logic [15:0] req_entity_number,
   input  logic [7:0]  req_entity_kind,
   input  logic [7:0]  req_entity_domain,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_verdict,
   input  logic [31:0] rsp_sequence_res,
   input  logic [31:0] rsp_folded_id,
   input  logic [1:0]  rsp_object_class,
   input  logic        rsp_sat_match,
   input  logic        rsp_fold_collision,
   input  logic [8:0]  rsp_tracked_count,
   input  logic [31:0] rsp_satellite_id,
   output int          error_count,
   output int          pending_count,
   output int          response_count,
   output int          accept_count,
   output int          stale_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [2:0]  verdict;
      logic [31:0] sequence_res;
      logic [31:0] folded_id;
      logic [1:0]  object_class;
      logic        sat_match;
      logic        fold_collision;
      logic [8:0]  tracked_count;
      logic [31:0] satellite_id;
   } filter_result_type;

   // register copies
   logic        filt_on;
   logic [7:0]  ex_match;
   logic [15:0] sat_site, sat_app, sat_ent;

   // table copies
   logic [47:0] age_key  [STALE_ENTRIES_DEF];
   logic [30:0] age_time [STALE_ENTRIES_DEF];
   bit          age_used [STALE_ENTRIES_DEF];
   logic [31:0] fold_id  [FOLD_ENTRIES_DEF];
   logic [47:0] fold_own [FOLD_ENTRIES_DEF];
   bit          fold_used[FOLD_ENTRIES_DEF];
   int          fold_total;
   logic [31:0] seq_ctr;
   logic [31:0] sat_fold;

   filter_result_type expected_q[$];

   assign pending_count = expected_q.size();

   // work out the response of the request on the ports right now
   function automatic filter_result_type predict_response();
      filter_result_type r;
      logic [30:0] ts;
      logic [47:0] key;
      logic [47:0] id_bytes;
      logic [31:0] h;
      int i, free_slot;
      bit found;
      r = '{default: '0};
      ts = req_raw_timestamp[31:1];
      key = {req_entity_site, req_entity_app, req_entity_number};
      if (req_packet_length < HDR_BYTES || req_version < VER_MIN || req_version > VER_MAX)
         r.verdict = VD_MALFORM;
      else if (filt_on && req_exercise != ex_match)
         r.verdict = VD_EXERCISE;
      else if (req_pdu_kind != ES_KIND)
         r.verdict = VD_OTHER;
      else if (!req_body_complete)
         r.verdict = VD_MALFORM;
      else begin
         // look up the entity's last time, insert it when unknown
         r.verdict = VD_ACCEPT;
         found = 0;
         free_slot = -1;
         for (i = 0; i < STALE_ENTRIES_DEF; i++) begin
            if (age_used[i]) begin
               if (age_key[i] == key) begin
                  found = 1;
                  if (ts == 0 || ts >= age_time[i] || (age_time[i] - ts) >= WRAP_GAP)
                     age_time[i] = ts;
                  else
                     r.verdict = VD_STALE;
                  break;
               end
            end else if (free_slot < 0) begin
               free_slot = i;
            end
         end
         if (!found && free_slot >= 0) begin
            age_used[free_slot] = 1;
            age_key[free_slot] = key;
            age_time[free_slot] = ts;
         end
      end

      if (r.verdict == VD_ACCEPT) begin
         seq_ctr++;
         r.sequence_res = seq_ctr;
         // fold the six id bytes, most significant first
         id_bytes = key;
         h = FNV_BASIS;
         for (i = 5; i >= 0; i--) begin
            h = (h ^ {24'd0, id_bytes[i*8 +: 8]}) * FNV_PRIME;
         end
         r.folded_id = h;
         r.sat_match = (req_entity_site == sat_site && req_entity_app == sat_app &&
                        req_entity_number == sat_ent);
         if (r.sat_match) begin
            sat_fold = h;
         end else begin
            found = 0;
            free_slot = -1;
            for (i = 0; i < FOLD_ENTRIES_DEF; i++) begin
               if (fold_used[i]) begin
                  if (fold_id[i] == h) begin
                     found = 1;
                     if (fold_own[i] != key) begin
                        fold_own[i] = key;
                        r.fold_collision = 1;
                     end
                     break;
                  end
               end else if (free_slot < 0) begin
                  free_slot = i;
               end
            end
            if (!found && free_slot >= 0) begin
               fold_used[free_slot] = 1;
               fold_id[free_slot] = h;
               fold_own[free_slot] = key;
               fold_total++;
            end
            // classify by kind and domain
            if (req_entity_kind == 1 && req_entity_domain == 5)
               r.object_class = 2'd0;
            else if ((req_entity_kind == 1 || req_entity_kind == 3) && req_entity_domain == 1)
               r.object_class = 2'd1;
            else if (req_entity_kind == 2)
               r.object_class = 2'd2;
            else
               r.object_class = 2'd3;
         end
      end
      r.tracked_count = 9'((fold_total > MAX_TRACKED_DEF) ? MAX_TRACKED_DEF : fold_total);
      r.satellite_id = sat_fold;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t ns: response %0d %s mismatch, expected %0h, got %0h",
                  $time, response_count, name, want, got);
      end
   endtask

   initial begin
      error_count = 0;
      response_count = 0;
      accept_count = 0;
      stale_count = 0;
   end

   always @(posedge clock) begin
      filter_result_type want;
      if (reset) begin
         filt_on <= 0;
         ex_match <= 0;
         sat_site <= 0;
         sat_app <= 0;
         sat_ent <= 0;
         fold_total = 0;
         seq_ctr = 0;
         sat_fold = 0;
         for (int i = 0; i < STALE_ENTRIES_DEF; i++) age_used[i] = 0;
         for (int i = 0; i < FOLD_ENTRIES_DEF; i++) fold_used[i] = 0;
         expected_q.delete();
      end else begin
         // track register writes
         if (csr_we) begin
            case (csr_index)
               CSR_FILT_ON:  filt_on <= csr_wdata[0];
               CSR_EX_MATCH: ex_match <= csr_wdata[7:0];
               CSR_SAT_SITE: sat_site <= csr_wdata;
               CSR_SAT_APP:  sat_app <= csr_wdata;
               CSR_SAT_ENT:  sat_ent <= csr_wdata;
               default: ;
            endcase
         end
         // predict each accepted request
         if (req_valid && req_ready) begin
            want = predict_response();
            if (want.verdict == VD_ACCEPT) accept_count++;
            if (want.verdict == VD_STALE) stale_count++;
            expected_q = {expected_q, want};
         end
         // compare each accepted response with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               error_count++;
               $display("%0t ns: response with nothing expected, verdict %0d",
                        $time, rsp_verdict);
            end else begin
               want = expected_q.pop_front();
               check_field("verdict", want.verdict, rsp_verdict);
               check_field("sequence_res", want.sequence_res, rsp_sequence_res);
               check_field("folded_id", want.folded_id, rsp_folded_id);
               check_field("object_class", want.object_class, rsp_object_class);
               check_field("sat_match", want.sat_match, rsp_sat_match);
               check_field("fold_collision", want.fold_collision, rsp_fold_collision);
               check_field("tracked_count", want.tracked_count, rsp_tracked_count);
               check_field("satellite_id", want.satellite_id, rsp_satellite_id);
            end
            response_count++;
         end
      end
   end

endmodule

// ===== test/tb_dis_entity_state_filter.sv =====
// ----------------------------------------------------------------------------
// tb_dis_entity_state_filter
// Drives directed and random entity state requests through the filter across
// several register settings and handshake idling phases; the monitor judges.
// ----------------------------------------------------------------------------
module tb_dis_entity_state_filter;
   import desf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POOL_SIZE = 40;
   localparam int RANDOM_PER_PHASE = 330;

   typedef struct {
      logic [15:0] packet_length;
      logic [7:0]  version;
      logic [7:0]  exercise;
      logic [7:0]  pdu_kind;
      logic [31:0] raw_timestamp;
      logic        body_complete;
      logic [15:0] entity_site;
      logic [15:0] entity_app;
      logic [15:0] entity_number;
      logic [7:0]  entity_kind;
      logic [7:0]  entity_domain;
   } pdu_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;
   logic        req_valid = 0;
   logic        req_ready;
   logic [15:0] req_packet_length = '0;
   logic [7:0]  req_version = '0;
   logic [7:0]  req_exercise = '0;
   logic [7:0]  req_pdu_kind = '0;
   logic [31:0] req_raw_timestamp = '0;
   logic        req_body_complete = 0;
   logic [15:0] req_entity_site = '0;
   logic [15:0] req_entity_app = '0;
   logic [15:0] req_entity_number = '0;
   logic [7:0]  req_entity_kind = '0;
   logic [7:0]  req_entity_domain = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [2:0]  rsp_verdict;
   logic [31:0] rsp_sequence_res;
   logic [31:0] rsp_folded_id;
   logic [1:0]  rsp_object_class;
   logic        rsp_sat_match;
   logic        rsp_fold_collision;
   logic [8:0]  rsp_tracked_count;
   logic [31:0] rsp_satellite_id;

   int error_count, pending_count, response_count, accept_count, stale_count;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int requests_sent = 0;

   // stimulus-side view of the setup
   logic        filter_now = 0;
   logic [7:0]  match_now = 0;
   logic [15:0] sat_s, sat_a, sat_e;
   logic [15:0] pool_site[POOL_SIZE], pool_app[POOL_SIZE], pool_num[POOL_SIZE];
   logic [30:0] pool_ts[POOL_SIZE];

   dis_entity_state_filter uut (.*);
   desf_monitor u_monitor (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // receiver stalls at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   initial begin
      #60000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic send_pdu(input pdu_type p);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1;
      req_packet_length <= p.packet_length;
      req_version <= p.version;
      req_exercise <= p.exercise;
      req_pdu_kind <= p.pdu_kind;
      req_raw_timestamp <= p.raw_timestamp;
      req_body_complete <= p.body_complete;
      req_entity_site <= p.entity_site;
      req_entity_app <= p.entity_app;
      req_entity_number <= p.entity_number;
      req_entity_kind <= p.entity_kind;
      req_entity_domain <= p.entity_domain;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
   endtask

   // hold off until every response is back
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_setup(input logic fon, input logic [7:0] match,
                              input logic [15:0] s, input logic [15:0] a,
                              input logic [15:0] e);
      logic [2:0]  idx [5];
      logic [15:0] val [5];
      idx = '{CSR_FILT_ON, CSR_EX_MATCH, CSR_SAT_SITE, CSR_SAT_APP, CSR_SAT_ENT};
      val = '{{15'd0, fon}, {8'd0, match}, s, a, e};
      for (int i = 0; i < 5; i++) begin
         csr_we <= 1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
      end
      csr_we <= 0;
      filter_now = fon;
      match_now = match;
      sat_s = s;
      sat_a = a;
      sat_e = e;
   endtask

   function automatic pdu_type good_pdu(input logic [15:0] s, input logic [15:0] a,
                                        input logic [15:0] e, input logic [30:0] ts);
      pdu_type p;
      p.packet_length = 16'd144;
      p.version = VER_MIN;
      p.exercise = match_now;
      p.pdu_kind = ES_KIND;
      p.raw_timestamp = {ts, 1'b1};
      p.body_complete = 1'b1;
      p.entity_site = s;
      p.entity_app = a;
      p.entity_number = e;
      p.entity_kind = 8'd1;
      p.entity_domain = 8'd1;
      return p;
   endfunction

   function automatic pdu_type random_pdu();
      pdu_type p;
      int r, k;
      logic [30:0] ts;
      r = $urandom_range(99);
      // noise: every field fully random
      if (r < 12) begin
         p.packet_length = 16'($urandom);
         p.version = 8'($urandom);
         p.exercise = 8'($urandom);
         p.pdu_kind = 8'($urandom);
         p.raw_timestamp = $urandom;
         p.body_complete = 1'($urandom);
         p.entity_site = 16'($urandom);
         p.entity_app = 16'($urandom);
         p.entity_number = 16'($urandom);
         p.entity_kind = 8'($urandom);
         p.entity_domain = 8'($urandom);
         return p;
      end
      k = $urandom_range(POOL_SIZE - 1);
      r = $urandom_range(99);
      if (r < 5) ts = '0;
      else if (r < 60) ts = 31'(pool_ts[k] + $urandom_range(1, 5000));
      else if (r < 78) ts = 31'(pool_ts[k] - $urandom_range(0, 5000));
      else if (r < 90)
         ts = 31'(pool_ts[k] - (31'h4000_0000 + $urandom_range(0, 31'h1000_0000)));
      else ts = 31'($urandom);
      pool_ts[k] = ts;
      p = good_pdu(pool_site[k], pool_app[k], pool_num[k], ts);
      // fresh entities fill the tables
      if ($urandom_range(99) < 33) begin
         p.entity_site = 16'($urandom);
         p.entity_app = 16'($urandom);
         p.entity_number = 16'($urandom);
      end else if ($urandom_range(99) < 4) begin
         p.entity_site = sat_s;
         p.entity_app = sat_a;
         p.entity_number = sat_e;
      end
      p.raw_timestamp[0] = 1'($urandom);
      p.packet_length = 16'($urandom_range(12, 65535));
      p.version = 8'($urandom_range(VER_MIN, VER_MAX));
      if (!filter_now || $urandom_range(99) < 15) p.exercise = 8'($urandom);
      if ($urandom_range(99) < 5) p.pdu_kind = 8'($urandom);
      if ($urandom_range(99) < 5) p.body_complete = 1'b0;
      r = $urandom_range(5);
      case (r)
         0: begin p.entity_kind = 8'd1; p.entity_domain = 8'd5; end
         1: begin p.entity_kind = 8'd1; p.entity_domain = 8'd1; end
         2: begin p.entity_kind = 8'd3; p.entity_domain = 8'd1; end
         3: begin p.entity_kind = 8'd2; p.entity_domain = 8'($urandom); end
         default: begin p.entity_kind = 8'($urandom); p.entity_domain = 8'($urandom); end
      endcase
      return p;
   endfunction

   task automatic directed_items();
      pdu_type p;
      // length edges
      p = good_pdu(16'h0000, 16'h0000, 16'h0000, 31'd10); p.packet_length = 0; send_pdu(p);
      p.packet_length = 11; send_pdu(p);
      p.packet_length = 12; send_pdu(p);
      p = good_pdu(16'hFFFF, 16'hFFFF, 16'hFFFE, 31'h7FFF_FFFF);
      p.packet_length = 16'hFFFF; send_pdu(p);
      // version edges
      p.version = 4; send_pdu(p);
      p.version = 8; send_pdu(p);
      p.version = 8'hFF; send_pdu(p);
      p.version = VER_MAX; p.raw_timestamp = 32'hFFFF_FFFF; send_pdu(p);
      // other PDU type and short body
      p.pdu_kind = 0; send_pdu(p);
      p.pdu_kind = 8'hFF; send_pdu(p);
      p.pdu_kind = ES_KIND; p.body_complete = 0; send_pdu(p);
      // stale, zero time, hourly wrap
      p = good_pdu(16'h1234, 16'h5678, 16'h9ABC, 31'd1000); send_pdu(p);
      p = good_pdu(16'h1234, 16'h5678, 16'h9ABC, 31'd500); send_pdu(p);
      p = good_pdu(16'h1234, 16'h5678, 16'h9ABC, 31'd0); send_pdu(p);
      p = good_pdu(16'h1234, 16'h5678, 16'h9ABC, 31'h7000_0000); send_pdu(p);
      p = good_pdu(16'h1234, 16'h5678, 16'h9ABC, 31'h6FFF_FFFF); send_pdu(p);
      p = good_pdu(16'h1234, 16'h5678, 16'h9ABC, 31'h0000_0010); send_pdu(p);
      // satellite and each classification
      p = good_pdu(sat_s, sat_a, sat_e, 31'd7); send_pdu(p);
      p = good_pdu(16'd1, 16'd2, 16'd3, 31'd7); p.entity_domain = 5; send_pdu(p);
      p = good_pdu(16'd1, 16'd2, 16'd4, 31'd7); p.entity_kind = 3; send_pdu(p);
      p = good_pdu(16'd1, 16'd2, 16'd5, 31'd7); p.entity_kind = 2; send_pdu(p);
      p = good_pdu(16'd1, 16'd2, 16'd6, 31'd7); p.entity_kind = 0; p.entity_domain = 0;
      send_pdu(p);
   endtask

   initial begin
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_site[i] = 16'($urandom);
         pool_app[i] = 16'($urandom);
         pool_num[i] = 16'($urandom);
         pool_ts[i] = 31'($urandom_range(0, 1000000));
      end
      sat_s = pool_site[0];
      sat_a = pool_app[0];
      sat_e = pool_num[0];
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // no idling, filter off
      write_setup(1'b0, 8'd0, pool_site[0], pool_app[0], pool_num[0]);
      directed_items();
      for (int i = 0; i < RANDOM_PER_PHASE; i++) send_pdu(random_pdu());
      drain();

      // sender idles, filter on the top exercise, all-ones satellite
      send_idle_pct = 81;
      write_setup(1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      begin
         pdu_type p;
         p = good_pdu(16'hFFFF, 16'hFFFF, 16'hFFFF, 31'd3); send_pdu(p);
         p.exercise = 8'h00; send_pdu(p);
      end
      for (int i = 0; i < RANDOM_PER_PHASE; i++) send_pdu(random_pdu());
      drain();

      // receiver stalls, filter on exercise zero, all-zero satellite
      send_idle_pct = 0;
      rsp_stall_pct = 81;
      write_setup(1'b1, 8'h00, 16'h0000, 16'h0000, 16'h0000);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
         if (i == RANDOM_PER_PHASE / 2) drain();
         send_pdu(random_pdu());
      end
      drain();

      // both idle lightly, filter off
      send_idle_pct = 10;
      rsp_stall_pct = 10;
      write_setup(1'b0, 8'($urandom), pool_site[0], pool_app[0], pool_num[0]);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) send_pdu(random_pdu());
      drain();
      repeat (400) @(posedge clock);

      $display("Sent %0d requests over four idling phases; %0d responses, %0d accepted,",
               requests_sent, response_count, accept_count);
      $display("%0d stale, with table fill, satellite and filter settings exercised.",
               stale_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
